[rtl/core/dnd_pkg.sv]
package dnd_pkg;

	localparam int STORE_DEPTH    = 512;
	localparam int MAX_NAME_BYTES = 256;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int CUR_W          = 14;
	localparam int CNT_W          = $clog2(MAX_NAME_BYTES);
	localparam int EPOCH_W        = 8;

	localparam logic [7:0] PTR_MARK      = 8'hC0;
	localparam logic [7:0] PTR_HIGH_MASK = 8'h3F;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_LOOP     = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_OOB      = 2'd3;

	typedef struct packed {
		logic       func;
		logic [8:0] load_address;
		logic [7:0] load_byte;
		logic [8:0] start_offset;
	} req_t;

	typedef struct packed {
		logic [63:0] name_word;
		logic [3:0]  byte_count;
		logic        last;
		logic [9:0]  wire_length;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic       load_wr;
		logic       start;
		logic       rd;
		logic       emit;
		logic       set_rem;
		logic       dec_rem;
		logic       inc_cur;
		logic       zero_wire;
		logic       ptr_mark;
		logic       ptr_jump;
		logic       push_final;
		logic [1:0] fin_status;
		logic       clr_wr;
		logic       clr_start;
		logic       epoch_inc;
		logic       epoch_one;
	} cmd_t;

	typedef struct packed {
		logic cur_oob;
		logic next_oob;
		logic is_zero;
		logic is_ptr;
		logic vis_hit;
		logic in_label;
		logic name_full;
		logic slot7;
		logic out_free;
		logic epoch_max;
		logic clr_done;
	} sts_t;

endpackage

[rtl/core/dnd_ram.sv]
module dnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/core/dnd_ctrl.sv]
module dnd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  dnd_pkg::req_t req,
	output logic          req_stall,
	input  dnd_pkg::sts_t sts,
	output dnd_pkg::cmd_t cmd
);
	import dnd_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_PTR2 = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] status_q, status_d;
	logic       clr_query_q, clr_query_d;
	logic       acc;
	logic       can_emit;

	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;
	assign can_emit  = !sts.slot7 || sts.out_free;

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		clr_query_d = clr_query_q;
		cmd         = '0;
		cmd.fin_status = status_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					if (clr_query_q) begin
						cmd.epoch_one = 1'b1;
						state_d = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				if (acc) begin
					if (req.func == FUNC_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.start = 1'b1;
						status_d  = ST_OK;
						if (sts.epoch_max) begin
							cmd.clr_start = 1'b1;
							clr_query_d   = 1'b1;
							state_d       = S_CLR;
						end else begin
							cmd.epoch_inc = 1'b1;
							state_d       = S_RD;
						end
					end
				end
			end
			S_RD: begin
				if (sts.cur_oob) begin
					status_d = ST_OOB;
					state_d  = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.in_label || (!sts.is_zero && !sts.is_ptr)) begin
					if (sts.name_full) begin
						status_d = ST_TOO_LONG;
						state_d  = S_FIN;
					end else if (can_emit) begin
						cmd.emit    = 1'b1;
						cmd.inc_cur = 1'b1;
						cmd.dec_rem = sts.in_label;
						cmd.set_rem = !sts.in_label;
						state_d     = S_RD;
					end
				end else if (sts.is_zero) begin
					if (sts.name_full) begin
						status_d = ST_TOO_LONG;
						state_d  = S_FIN;
					end else if (can_emit) begin
						cmd.emit      = 1'b1;
						cmd.zero_wire = 1'b1;
						status_d      = ST_OK;
						state_d       = S_FIN;
					end
				end else if (sts.vis_hit) begin
					status_d = ST_LOOP;
					state_d  = S_FIN;
				end else begin
					cmd.ptr_mark = 1'b1;
					if (sts.next_oob) begin
						status_d = ST_OOB;
						state_d  = S_FIN;
					end else begin
						state_d = S_PTR2;
					end
				end
			end
			S_PTR2: begin
				cmd.ptr_jump = 1'b1;
				state_d      = S_RD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.push_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			status_q    <= ST_OK;
			clr_query_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			status_q    <= status_d;
			clr_query_q <= (state_q == S_CLR && sts.clr_done) ? 1'b0 : clr_query_d;
		end
	end
endmodule

[rtl/core/dnd_dp.sv]
module dnd_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  dnd_pkg::req_t req,
	input  dnd_pkg::cmd_t cmd,
	output dnd_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dnd_pkg::rsp_t rsp
);
	import dnd_pkg::*;

	logic [CUR_W-1:0]   cur_q;
	logic [ADDR_W-1:0]  start_q;
	logic [7:0]         rem_q;
	logic               ptr_taken_q;
	logic [9:0]         wire_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [63:0]        pack_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [7:0]         sdata;
	logic [EPOCH_W-1:0] vdata;
	logic [ADDR_W-1:0]  cur_a;
	logic [ADDR_W-1:0]  store_raddr;
	logic               vis_we;
	logic [ADDR_W-1:0]  vis_waddr;
	logic [EPOCH_W-1:0] vis_wdata;
	logic [9:0]         wire_base;
	logic [2:0]         slot;
	logic [63:0]        pack_next;

	assign cur_a       = cur_q[ADDR_W-1:0];
	assign store_raddr = cmd.ptr_mark ? (cur_a + 1'b1) : cur_a;
	assign vis_we      = cmd.clr_wr || cmd.ptr_mark;
	assign vis_waddr   = cmd.clr_wr ? clr_cnt_q : cur_a;
	assign vis_wdata   = cmd.clr_wr ? '0 : epoch_q;
	assign wire_base   = {1'b0, cur_a} - {1'b0, start_q};
	assign slot        = cnt_q[2:0];
	assign pack_next   = pack_q | ({56'd0, sdata} << {slot, 3'b000});

	dnd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (req.load_address),
		.wdata (req.load_byte),
		.re    (cmd.rd || cmd.ptr_mark),
		.raddr (store_raddr),
		.rdata (sdata)
	);

	dnd_ram #(.WIDTH(EPOCH_W), .DEPTH(STORE_DEPTH)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (cmd.rd),
		.raddr (cur_a),
		.rdata (vdata)
	);

	always_comb begin
		sts.cur_oob   = (cur_q >= CUR_W'(STORE_DEPTH));
		sts.next_oob  = (cur_a == ADDR_W'(STORE_DEPTH - 1));
		sts.is_zero   = (sdata == 8'd0);
		sts.is_ptr    = ((sdata & PTR_MARK) == PTR_MARK);
		sts.vis_hit   = (vdata == epoch_q);
		sts.in_label  = (rem_q != 8'd0);
		sts.name_full = (cnt_q == CNT_W'(MAX_NAME_BYTES - 1));
		sts.slot7     = (slot == 3'd7);
		sts.out_free  = !rsp_valid_q || !rsp_stall;
		sts.epoch_max = (epoch_q == '1);
		sts.clr_done  = (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			epoch_q     <= '0;
			clr_cnt_q   <= '0;
		end else begin
			if (cmd.clr_start) begin
				clr_cnt_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.epoch_one) begin
				epoch_q <= EPOCH_W'(1);
			end else if (cmd.epoch_inc) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (cmd.push_final || (cmd.emit && slot == 3'd7)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q       <= CUR_W'(req.start_offset);
			start_q     <= req.start_offset;
			rem_q       <= 8'd0;
			ptr_taken_q <= 1'b0;
			wire_q      <= 10'd0;
			cnt_q       <= '0;
			pack_q      <= '0;
		end
		if (cmd.inc_cur) begin
			cur_q <= cur_q + 1'b1;
		end
		if (cmd.set_rem) begin
			rem_q <= sdata;
		end else if (cmd.dec_rem) begin
			rem_q <= rem_q - 1'b1;
		end
		if (cmd.zero_wire && !ptr_taken_q) begin
			wire_q <= wire_base + 10'd1;
		end
		if (cmd.ptr_mark) begin
			if (!ptr_taken_q) begin
				wire_q <= wire_base + 10'd2;
			end
			ptr_taken_q <= 1'b1;
			cur_q       <= {sdata[5:0] & PTR_HIGH_MASK[5:0], 8'd0};
		end
		if (cmd.ptr_jump) begin
			cur_q <= {cur_q[CUR_W-1:8], sdata};
		end
		if (cmd.emit) begin
			cnt_q <= cnt_q + 1'b1;
			if (slot == 3'd7) begin
				rsp_q.name_word   <= pack_next;
				rsp_q.byte_count  <= 4'd8;
				rsp_q.last        <= 1'b0;
				rsp_q.wire_length <= 10'd0;
				rsp_q.status      <= ST_OK;
				pack_q            <= '0;
			end else begin
				pack_q <= pack_next;
			end
		end
		if (cmd.push_final) begin
			rsp_q.name_word   <= pack_q;
			rsp_q.byte_count  <= {1'b0, slot};
			rsp_q.last        <= 1'b1;
			rsp_q.wire_length <= (cmd.fin_status == ST_OK) ? wire_q : 10'd0;
			rsp_q.status      <= cmd.fin_status;
			pack_q            <= '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

[rtl/core/dns_name_decompressor.sv]
// Load transaction: stored when accepted. Decode: accept; read and evaluate per label or
// zero byte (one store read port); read, evaluate and jump per pointer; close. The 256th
// decode after reset and every 255th after it first clears the visited map.
// Result words leave through an output register; a decode stalls only on a full one.
// Reset: asynchronous, active low; a visited-map clear follows with input stalled.
module dns_name_decompressor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dnd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dnd_pkg::rsp_t rsp
);
	import dnd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dnd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dnd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.byte_count == 4'd8)
		else $error("full word result without eight bytes");

	a_err_wire: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.wire_length == 10'd0)
		else $error("error result carries wire length");

	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_final || cmd.emit && sts.slot7) |-> sts.out_free)
		else $error("result pushed into busy output register");

	a_last_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> rsp.byte_count < 4'd8)
		else $error("final result with full count");
endmodule
